// ===== rtl/core/lvlb_pkg.sv =====
`timescale 1ns / 1ps

package lvlb_pkg;

    // field widths fixed by the item formats
    localparam int SITE_W   = 5;
    localparam int VERTEX_W = 12;
    localparam int CFG_W    = 6;
    localparam int POS_KEEP = VERTEX_W - 2;

    localparam logic [CFG_W-1:0] SITES_RESET = 6'd32;

    // one operator-string position
    typedef struct packed {
        logic              has_operator;
        logic [SITE_W-1:0] site_one;
        logic [SITE_W-1:0] site_two;
        logic              final_position;
    } op_item_t;

    // one link pair
    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic                run_end;
    } link_item_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEG1,
        ST_LEG2,
        ST_SCAN,
        ST_CLOSE,
        ST_FLUSH
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic leg1;
        logic leg2;
        logic scan_read;
        logic scan_step;
        logic close_emit;
        logic clear_seen;
        logic flush;
    } lvlb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_has_op;
        logic in_fin;
        logic item_fin;
        logic need1;
        logic need2;
        logic pend_valid;
        logic push_ok;
        logic scan_done;
        logic scan_seen;
    } lvlb_status_t;

endpackage

// ===== rtl/core/lvlb_ctrl.sv =====
`timescale 1ns / 1ps

module lvlb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op_valid,
    output logic                  op_ready,
    input  lvlb_pkg::lvlb_status_t st,
    output lvlb_pkg::lvlb_cmd_t    cmd
);
    import lvlb_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        op_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                op_ready = 1'b1;
                if (op_valid)
                begin
                    cmd.accept = 1'b1;
                    if (st.in_has_op)
                    begin
                        state_next = ST_LEG1;
                    end
                    else if (st.in_fin)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_LEG1:
            begin
                // hold while a new link has nowhere to go
                if (!(st.need1 && st.pend_valid && !st.push_ok))
                begin
                    cmd.leg1   = 1'b1;
                    state_next = ST_LEG2;
                end
            end
            ST_LEG2:
            begin
                if (!(st.need2 && st.pend_valid && !st.push_ok))
                begin
                    cmd.leg2   = 1'b1;
                    state_next = st.item_fin ? ST_SCAN : ST_FLUSH;
                end
            end
            ST_SCAN:
            begin
                // walk sites, step past unseen ones without a read
                if (st.scan_done)
                begin
                    cmd.clear_seen = 1'b1;
                    state_next     = ST_FLUSH;
                end
                else if (st.scan_seen)
                begin
                    cmd.scan_read = 1'b1;
                    state_next    = ST_CLOSE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_CLOSE:
            begin
                if (!(st.pend_valid && !st.push_ok))
                begin
                    cmd.close_emit = 1'b1;
                    cmd.scan_step  = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_FLUSH:
            begin
                // last held link goes out marked as run end
                if (!st.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (st.push_ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // second leg only follows the first leg
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEG2 && $past(state_reg) != ST_LEG2)
        |-> $past(state_reg) == ST_LEG1)
        else $error("leg2 entered without leg1");

    // closing pair only for a seen site inside the range
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLOSE && $past(state_reg) != ST_CLOSE)
        |-> ($past(st.scan_seen) && !$past(st.scan_done)))
        else $error("close step without a seen site");

    // scan leaves only when the range is done
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && $past(state_reg) == ST_SCAN)
        |-> $past(st.scan_done))
        else $error("scan left early");
`endif

endmodule

// ===== rtl/core/lvlb_datapath.sv =====
`timescale 1ns / 1ps

module lvlb_datapath #(
    parameter int MAX_LEN   = 1024,
    parameter int NUM_SITES = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lvlb_pkg::lvlb_cmd_t    cmd,
    output lvlb_pkg::lvlb_status_t st,
    input  lvlb_pkg::op_item_t     op_data,
    input  logic                  cfg_valid,
    input  logic [lvlb_pkg::CFG_W-1:0] cfg_data,
    input  logic                  link_ready,
    output logic                  link_valid,
    output lvlb_pkg::link_item_t   link_data
);
    import lvlb_pkg::*;

    localparam int SW  = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
    localparam int PCW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [CFG_W-1:0] SITES_MAX = CFG_W'(NUM_SITES);
    localparam logic [PCW-1:0]   POS_LAST  = PCW'(MAX_LEN - 1);

    // configuration and string position
    logic [CFG_W-1:0]    sites_reg;
    logic [PCW-1:0]      pos_reg;
    logic [PCW-1:0]      pos_next;
    logic [NUM_SITES-1:0] seen_reg;

    // captured item
    logic                fin_reg;
    logic [CFG_W-1:0]    s1_reg;
    logic [CFG_W-1:0]    s2_reg;
    logic                ok1_reg;
    logic                ok2_reg;
    logic                seen1_reg;
    logic                seen2_reg;
    logic [POS_KEEP-1:0] base_reg;

    // memory read data
    logic [VERTEX_W-1:0] rd_a_reg;
    logic [VERTEX_W-1:0] rd_b_reg;
    logic [VERTEX_W-1:0] rd_first_reg;

    // held link and output stage
    logic [VERTEX_W-1:0] pend_a_reg;
    logic [VERTEX_W-1:0] pend_b_reg;
    logic                pend_valid_reg;
    link_item_t          out_reg;
    logic                out_valid_reg;
    logic [CFG_W-1:0]    scan_reg;

    // per-site leg memories
    logic [VERTEX_W-1:0] first_mem  [NUM_SITES];
    logic [VERTEX_W-1:0] latest_mem [NUM_SITES];

    logic [CFG_W-1:0]    in_s1;
    logic [CFG_W-1:0]    in_s2;
    logic                in_ok1;
    logic                in_ok2;
    logic [PCW+VERTEX_W-1:0] pos_wide;
    logic [CFG_W-1:0]    lim;
    logic                need1;
    logic                need2;
    logic                push_ok;
    logic                produce;
    logic                push;
    logic [VERTEX_W-1:0] new_a;
    logic [VERTEX_W-1:0] new_b;
    logic                latest_we;
    logic [SW-1:0]       latest_waddr;
    logic [VERTEX_W-1:0] latest_wdata;
    logic                first_we;
    logic [SW-1:0]       first_waddr;
    logic [VERTEX_W-1:0] first_wdata;
    logic [SW-1:0]       scan_idx;

    // incoming sites and range check
    assign in_s1    = {1'b0, op_data.site_one};
    assign in_s2    = {1'b0, op_data.site_two};
    assign in_ok1   = in_s1 < SITES_MAX;
    assign in_ok2   = in_s2 < SITES_MAX;
    assign pos_wide = {{VERTEX_W{1'b0}}, pos_reg};
    assign lim      = (sites_reg > SITES_MAX) ? SITES_MAX : sites_reg;
    assign scan_idx = scan_reg[SW-1:0];

    assign need1   = ok1_reg && seen1_reg;
    assign need2   = ok2_reg && seen2_reg;
    assign push_ok = !out_valid_reg || link_ready;

    // status to the controller
    always_comb
    begin
        st.in_has_op  = op_data.has_operator;
        st.in_fin     = op_data.final_position;
        st.item_fin   = fin_reg;
        st.need1      = need1;
        st.need2      = need2;
        st.pend_valid = pend_valid_reg;
        st.push_ok    = push_ok;
        st.scan_done  = scan_reg >= lim;
        st.scan_seen  = seen_reg[scan_idx];
    end

    // position wraps, a final item restarts the string
    always_comb
    begin
        if (op_data.final_position || pos_reg == POS_LAST)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // leg writes, one site per cycle
    always_comb
    begin
        latest_we    = (cmd.leg1 && ok1_reg) || (cmd.leg2 && ok2_reg);
        latest_waddr = cmd.leg1 ? s1_reg[SW-1:0] : s2_reg[SW-1:0];
        latest_wdata = cmd.leg1 ? {base_reg, 2'b01} : {base_reg, 2'b11};
        first_we     = (cmd.leg1 && ok1_reg && !seen1_reg)
                    || (cmd.leg2 && ok2_reg && !seen2_reg);
        first_waddr  = cmd.leg1 ? s1_reg[SW-1:0] : s2_reg[SW-1:0];
        first_wdata  = cmd.leg1 ? {base_reg, 2'b00} : {base_reg, 2'b10};
    end

    // new link selection
    always_comb
    begin
        produce = (cmd.leg1 && need1) || (cmd.leg2 && need2) || cmd.close_emit;
        push    = (produce && pend_valid_reg) || cmd.flush;
        if (cmd.leg1)
        begin
            new_a = rd_a_reg;
            new_b = {base_reg, 2'b00};
        end
        else if (cmd.leg2)
        begin
            new_a = rd_b_reg;
            new_b = {base_reg, 2'b10};
        end
        else
        begin
            new_a = rd_a_reg;
            new_b = rd_first_reg;
        end
    end

    // leg memories
    always_ff @(posedge clk)
    begin
        if (latest_we)
        begin
            latest_mem[latest_waddr] <= latest_wdata;
        end
        if (first_we)
        begin
            first_mem[first_waddr] <= first_wdata;
        end
        if (cmd.accept)
        begin
            rd_a_reg <= latest_mem[in_s1[SW-1:0]];
            rd_b_reg <= latest_mem[in_s2[SW-1:0]];
        end
        else if (cmd.scan_read)
        begin
            rd_a_reg <= latest_mem[scan_idx];
        end
        if (cmd.scan_read)
        begin
            rd_first_reg <= first_mem[scan_idx];
        end
    end

    // captured item and held link payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            fin_reg   <= op_data.final_position;
            s1_reg    <= in_s1;
            s2_reg    <= in_s2;
            ok1_reg   <= in_ok1;
            ok2_reg   <= in_ok2;
            seen1_reg <= in_ok1 && seen_reg[in_s1[SW-1:0]];
            seen2_reg <= in_ok2 && seen_reg[in_s2[SW-1:0]];
            base_reg  <= pos_wide[POS_KEEP-1:0];
        end
        if (produce)
        begin
            pend_a_reg <= new_a;
            pend_b_reg <= new_b;
        end
        if (push)
        begin
            out_reg.vertex_a <= pend_a_reg;
            out_reg.vertex_b <= pend_b_reg;
            out_reg.run_end  <= cmd.flush;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sites_reg      <= SITES_RESET;
            pos_reg        <= '0;
            seen_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            scan_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                sites_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                pos_reg <= pos_next;
            end
            if (cmd.clear_seen)
            begin
                seen_reg <= '0;
            end
            else if (cmd.leg1 && ok1_reg)
            begin
                seen_reg[s1_reg[SW-1:0]] <= 1'b1;
            end
            else if (cmd.leg2 && ok2_reg)
            begin
                seen_reg[s2_reg[SW-1:0]] <= 1'b1;
            end
            if (produce)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (link_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.accept)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    assign link_valid = out_valid_reg;
    assign link_data  = out_reg;

`ifndef SYNTHESIS
    // a push never overwrites a link still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_ok)
        else $error("output overwritten");

    // every produced link is held for the next push
    assert property (@(posedge clk) disable iff (!rst_n)
        produce |=> pend_valid_reg)
        else $error("produced link lost");

    // closing a string leaves no site seen
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_seen |=> (seen_reg == '0))
        else $error("seen flags not cleared");
`endif

endmodule

// ===== rtl/core/linked_vertex_list_builder_top.sv =====
`timescale 1ns / 1ps
// channel | signals                          | direction
// op      | op_valid, op_ready, op_data      | position items in
// link    | link_valid, link_ready, link_data| link pair items out
// cfg     | cfg_valid, cfg_ready, cfg_data   | sites_in_use write
//
// an identity position is just accepted, an operator one runs accept,
// one leg step per site (single write port of the leg memories), then flush
// a final position also walks the sites in range, with a read and a closing pair
// for each seen site, then ends the walk and flushes
// rst_n clears position, seen flags and sites_in_use (to 32), not the memories
// a full link output holds the sequencer whenever a held link has to move on:
// at either leg step, at a closing pair or at the flush step

module linked_vertex_list_builder_top #(
    parameter int MAX_LEN   = 1024,
    parameter int NUM_SITES = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       op_valid,
    output logic                       op_ready,
    input  lvlb_pkg::op_item_t          op_data,
    output logic                       link_valid,
    input  logic                       link_ready,
    output lvlb_pkg::link_item_t        link_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lvlb_pkg::CFG_W-1:0] cfg_data
);
    import lvlb_pkg::*;

    lvlb_cmd_t    cmd;
    lvlb_status_t st;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer
    lvlb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // leg memories and link path
    lvlb_datapath #(
        .MAX_LEN   (MAX_LEN),
        .NUM_SITES (NUM_SITES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .op_data    (op_data),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .link_ready (link_ready),
        .link_valid (link_valid),
        .link_data  (link_data)
    );

endmodule
